FILE: design/rop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rop_pkg;

    // Command codes of an input request.
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Pixel update values.
    localparam logic [7:0] ACC_STEP  = 8'd63;
    localparam logic [7:0] SET_VALUE = 8'd127;

    // Edge order of one rectangle.
    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_TOP    = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    // Microprogram addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_CLR      = 4'd0;
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd1;
    localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd2;
    localparam logic [PC_W-1:0] STEP_FINITE   = 4'd3;
    localparam logic [PC_W-1:0] STEP_SETUP    = 4'd4;
    localparam logic [PC_W-1:0] STEP_SKIP     = 4'd5;
    localparam logic [PC_W-1:0] STEP_MREAD    = 4'd6;
    localparam logic [PC_W-1:0] STEP_MWRITE   = 4'd7;
    localparam logic [PC_W-1:0] STEP_NEXT     = 4'd8;
    localparam logic [PC_W-1:0] STEP_FIN      = 4'd9;
    localparam logic [PC_W-1:0] STEP_RD       = 4'd10;
    localparam logic [PC_W-1:0] STEP_RD_EMIT  = 4'd11;

    // Jump conditions.
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] COND_NEVER      = 4'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] COND_CLR_DONE   = 4'd2;
    localparam logic [COND_W-1:0] COND_REQ        = 4'd3;
    localparam logic [COND_W-1:0] COND_IS_READ    = 4'd4;
    localparam logic [COND_W-1:0] COND_NOT_FINITE = 4'd5;
    localparam logic [COND_W-1:0] COND_EDGE_SKIP  = 4'd6;
    localparam logic [COND_W-1:0] COND_CUR_MORE   = 4'd7;
    localparam logic [COND_W-1:0] COND_EDGE_MORE  = 4'd8;
    localparam logic [COND_W-1:0] COND_OUT_FREE   = 4'd9;

    typedef struct packed {
        logic              cmd;
        logic signed [7:0] x_first;
        logic signed [7:0] y_first;
        logic signed [7:0] x_second;
        logic signed [7:0] y_second;
        logic              coords_finite;
        logic              last_box;
        logic [5:0]        read_x;
        logic [5:0]        read_y;
    } rop_in_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [31:0] edge_count;
        logic        batch_done;
    } rop_out_t;

    // Datapath strobes of one microinstruction.
    typedef struct packed {
        logic clr_wr;
        logic take;
        logic edge_clr;
        logic setup;
        logic mem_rd;
        logic mem_wr;
        logic cur_inc;
        logic edge_inc;
        logic pix_rd;
        logic emit;
    } rop_ctrl_t;

    typedef struct packed {
        rop_ctrl_t         ctrl;
        logic [COND_W-1:0] cond;
        logic              stay;
        logic [PC_W-1:0]   target;
    } rop_uword_t;

    // Status flags returned by the datapath.
    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic not_finite;
        logic edge_skip;
        logic cur_more;
        logic edge_more;
    } rop_flags_t;

    // Control store. A true condition jumps to target; otherwise the step
    // either holds (stay) or falls through to the next address.
    function automatic rop_uword_t rop_urom(input logic [PC_W-1:0] pc);
        rop_uword_t w;
        w = '0;
        case (pc)
            STEP_CLR:
            begin
                w.ctrl.clr_wr = 1'b1;
                w.cond        = COND_CLR_DONE;
                w.target      = STEP_IDLE;
                w.stay        = 1'b1;
            end
            STEP_IDLE:
            begin
                w.ctrl.take = 1'b1;
                w.cond      = COND_REQ;
                w.target    = STEP_DISPATCH;
                w.stay      = 1'b1;
            end
            STEP_DISPATCH:
            begin
                w.cond   = COND_IS_READ;
                w.target = STEP_RD;
            end
            STEP_FINITE:
            begin
                w.ctrl.edge_clr = 1'b1;
                w.cond          = COND_NOT_FINITE;
                w.target        = STEP_FIN;
            end
            STEP_SETUP:
            begin
                w.ctrl.setup = 1'b1;
                w.cond       = COND_NEVER;
            end
            STEP_SKIP:
            begin
                w.cond   = COND_EDGE_SKIP;
                w.target = STEP_NEXT;
            end
            STEP_MREAD:
            begin
                w.ctrl.mem_rd = 1'b1;
                w.cond        = COND_NEVER;
            end
            STEP_MWRITE:
            begin
                w.ctrl.mem_wr  = 1'b1;
                w.ctrl.cur_inc = 1'b1;
                w.cond         = COND_CUR_MORE;
                w.target       = STEP_MREAD;
            end
            STEP_NEXT:
            begin
                w.ctrl.edge_inc = 1'b1;
                w.cond          = COND_EDGE_MORE;
                w.target        = STEP_SETUP;
            end
            STEP_FIN:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.target    = STEP_IDLE;
                w.stay      = 1'b1;
            end
            STEP_RD:
            begin
                w.ctrl.pix_rd = 1'b1;
                w.cond        = COND_NEVER;
            end
            STEP_RD_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.target    = STEP_IDLE;
                w.stay      = 1'b1;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/rop_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rop_seq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 out_free,
    input  rop_pkg::rop_flags_t flags,
    output rop_pkg::rop_ctrl_t  ctrl
);
    import rop_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    rop_uword_t      uword;
    logic            cond_true;

    assign uword = rop_urom(pc_reg);
    assign ctrl  = uword.ctrl;

    always_comb
    begin
        case (uword.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_CLR_DONE:   cond_true = flags.clr_done;
            COND_REQ:        cond_true = in_valid;
            COND_IS_READ:    cond_true = flags.is_read;
            COND_NOT_FINITE: cond_true = flags.not_finite;
            COND_EDGE_SKIP:  cond_true = flags.edge_skip;
            COND_CUR_MORE:   cond_true = flags.cur_more;
            COND_EDGE_MORE:  cond_true = flags.edge_more;
            COND_OUT_FREE:   cond_true = out_free;
            default:         cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        if (cond_true)
            pc_next = uword.target;
        else if (uword.stay)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_CLR;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

FILE: design/rop_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rop_dp #(
    parameter int RASTER_WIDTH  = 64,
    parameter int RASTER_HEIGHT = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rop_pkg::rop_ctrl_t  ctrl,
    input  wire                 in_valid,
    input  rop_pkg::rop_in_t    in_data,
    input  wire                 acc_mode,
    output rop_pkg::rop_flags_t flags,
    output rop_pkg::rop_out_t   result
);
    import rop_pkg::*;

    localparam int STORE_SIZE = RASTER_WIDTH * RASTER_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [31:0] X_LIM = 32'(RASTER_WIDTH);
    localparam logic [31:0] Y_LIM = 32'(RASTER_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    logic [7:0] mem [STORE_SIZE];

    rop_in_t           item_reg;
    logic [1:0]        edge_reg;
    logic [6:0]        fixed_reg;
    logic [6:0]        cur_reg;
    logic [6:0]        hi_reg;
    logic              vert_reg;
    logic              skip_reg;
    logic [31:0]       count_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [7:0]        rdata_reg;
    logic              pix_ok_reg;

    logic              vert;
    logic signed [7:0] fixed;
    logic signed [7:0] run_a;
    logic signed [7:0] run_b;
    logic signed [7:0] lo;
    logic signed [7:0] hi;
    logic [31:0]       run_lim;
    logic [31:0]       fixed_lim;
    logic              skip;
    logic [6:0]        px;
    logic [6:0]        py;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
    logic [7:0]        draw_data;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    // Left and right edges run along y; top and bottom run along x.
    always_comb
    begin
        vert = (edge_reg == EDGE_LEFT) || (edge_reg == EDGE_RIGHT);
        case (edge_reg)
            EDGE_LEFT:   fixed = item_reg.x_first;
            EDGE_TOP:    fixed = item_reg.y_first;
            EDGE_BOTTOM: fixed = item_reg.y_second;
            EDGE_RIGHT:  fixed = item_reg.x_second;
            default:     fixed = item_reg.x_first;
        endcase
        run_a     = vert ? item_reg.y_first : item_reg.x_first;
        run_b     = vert ? item_reg.y_second : item_reg.x_second;
        lo        = (run_a < run_b) ? run_a : run_b;
        hi        = (run_a < run_b) ? run_b : run_a;
        run_lim   = vert ? Y_LIM : X_LIM;
        fixed_lim = vert ? X_LIM : Y_LIM;
        skip      = lo[7] || fixed[7]
                    || ({24'd0, hi} >= run_lim) || ({24'd0, fixed} >= fixed_lim);
    end

    always_comb
    begin
        px        = vert_reg ? fixed_reg : cur_reg;
        py        = vert_reg ? cur_reg : fixed_reg;
        draw_addr = ADDR_W'(int'(py) * RASTER_WIDTH + int'(px));
        rd_addr   = ADDR_W'(int'(item_reg.read_y) * RASTER_WIDTH + int'(item_reg.read_x));
        rd_ok     = ({26'd0, item_reg.read_x} < X_LIM) && ({26'd0, item_reg.read_y} < Y_LIM);
        draw_data = acc_mode ? (rdata_reg + ACC_STEP) : SET_VALUE;
        we        = ctrl.clr_wr || ctrl.mem_wr;
        waddr     = ctrl.clr_wr ? clr_addr_reg : draw_addr;
        wdata     = ctrl.clr_wr ? 8'd0 : draw_data;
        re        = ctrl.mem_rd || ctrl.pix_rd;
        raddr     = ctrl.pix_rd ? rd_addr : draw_addr;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take && in_valid)
            item_reg <= in_data;
        if (ctrl.setup)
        begin
            fixed_reg <= fixed[6:0];
            cur_reg   <= lo[6:0];
            hi_reg    <= hi[6:0];
            vert_reg  <= vert;
            skip_reg  <= skip;
        end
        else if (ctrl.cur_inc)
            cur_reg <= cur_reg + 7'd1;
        if (ctrl.pix_rd)
            pix_ok_reg <= rd_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg     <= EDGE_LEFT;
            count_reg    <= 32'd0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (ctrl.edge_clr)
                edge_reg <= EDGE_LEFT;
            else if (ctrl.edge_inc)
                edge_reg <= edge_reg + 2'd1;
            if (ctrl.setup)
                count_reg <= count_reg + 32'd1;
            if (ctrl.clr_wr)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign flags.clr_done   = (clr_addr_reg == LAST_ADDR);
    assign flags.is_read    = (item_reg.cmd == CMD_READ);
    assign flags.not_finite = !item_reg.coords_finite;
    assign flags.edge_skip  = skip_reg;
    assign flags.cur_more   = (cur_reg != hi_reg);
    assign flags.edge_more  = (edge_reg != EDGE_RIGHT);

    assign result.pixel_value = (item_reg.cmd == CMD_READ && pix_ok_reg) ? rdata_reg : 8'd0;
    assign result.edge_count  = count_reg;
    assign result.batch_done  = (item_reg.cmd == CMD_DRAW) && item_reg.last_box;

endmodule

`default_nettype wire

FILE: design/rectangle_outline_plotter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake         Payload
// in        in_valid/in_stall   rop_in_t  draw or read request
// out       out_valid/out_stall rop_out_t one result per request
// cfg       cfg_valid/cfg_ready cfg_data  accumulate mode bit
//
// After reset the frame store is cleared one pixel a cycle; no request is
// taken during that pass. A draw request sets up edges in turn: left, top,
// bottom, right. Per plotted pixel it does one read and one write on the
// frame store. A finished result sits in the output register, and the next
// request is taken while it waits; only a second result waits on out_stall.

module rectangle_outline_plotter_top #(
    parameter int RASTER_WIDTH  = 64,
    parameter int RASTER_HEIGHT = 64
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  rop_pkg::rop_in_t  in_data,
    output logic              out_valid,
    input  wire               out_stall,
    output rop_pkg::rop_out_t out_data,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire               cfg_data
);
    import rop_pkg::*;

    rop_ctrl_t  ctrl;
    rop_flags_t flags;
    rop_out_t   result;
    rop_out_t   out_data_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       emit_fire;
    logic       acc_mode_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = ctrl.emit && out_free;
    assign in_stall  = !ctrl.take;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rop_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    rop_dp #(
        .RASTER_WIDTH  (RASTER_WIDTH),
        .RASTER_HEIGHT (RASTER_HEIGHT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_valid (in_valid),
        .in_data  (in_data),
        .acc_mode (acc_mode_reg),
        .flags    (flags),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_mode_reg  <= 1'b1;
        end
        else
        begin
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                acc_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire

FILE: tb/rectangle_outline_plotter_top_tb.sv
`timescale 1ns / 1ps

module rectangle_outline_plotter_top_tb;

    import rop_pkg::*;

    localparam int RW           = 64;
    localparam int RH           = 64;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 600;
    localparam int PHASE_ITEMS  = 250;

    logic     clk       = 1'b1;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    rop_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    rop_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;

    rectangle_outline_plotter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Shadow copy of the raster and the edge counter.
    logic [7:0]  shadow_frame [0:RW*RH-1];
    logic [31:0] edge_total;
    logic        acc_mode;

    rop_in_t  requests_q[$];
    rop_out_t due_results[$];
    bit       offering;
    int       gap_left;
    int       stall_left;
    int       hold_left;
    logic     hold_req = 1'b0;
    int       in_idle_pct;
    int       out_idle_pct;
    int       mismatch_count;
    int       mark_x;
    int       mark_y;

    task automatic draw_edge(input int xa, input int ya, input int xb, input int yb);
        int lx;
        int gx;
        int ly;
        int gy;
        int idx;
        lx = (xa < xb) ? xa : xb;
        gx = (xa < xb) ? xb : xa;
        ly = (ya < yb) ? ya : yb;
        gy = (ya < yb) ? yb : ya;
        edge_total = edge_total + 32'd1;
        // Edges that leave the raster on either side are counted only.
        if (lx < 0 || ly < 0 || gx >= RW || gy >= RH)
            return;
        if (gx == lx)
        begin
            for (int i = ly; i <= gy; i++)
            begin
                idx = i * RW + lx;
                shadow_frame[idx] = acc_mode ? shadow_frame[idx] + ACC_STEP : SET_VALUE;
            end
        end
        else
        begin
            for (int i = lx; i <= gx; i++)
            begin
                idx = ly * RW + i;
                shadow_frame[idx] = acc_mode ? shadow_frame[idx] + ACC_STEP : SET_VALUE;
            end
        end
    endtask

    task automatic trace_request(input rop_in_t r, output rop_out_t res);
        int xa;
        int ya;
        int xb;
        int yb;
        res = '0;
        if (r.cmd == CMD_DRAW)
        begin
            if (r.coords_finite)
            begin
                xa = int'($signed(r.x_first));
                ya = int'($signed(r.y_first));
                xb = int'($signed(r.x_second));
                yb = int'($signed(r.y_second));
                draw_edge(xa, ya, xa, yb);
                draw_edge(xa, ya, xb, ya);
                draw_edge(xa, yb, xb, yb);
                draw_edge(xb, yb, xb, ya);
            end
            res.batch_done = r.last_box;
        end
        else
        begin
            res.pixel_value = shadow_frame[{r.read_y, r.read_x}];
        end
        res.edge_count = edge_total;
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Driver: takes requests from the queue and holds each until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            gap_left = 0;
        end
        else
        begin
            rop_out_t res;
            bit       next_valid;
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                trace_request(in_data, res);
                due_results.push_back(res);
                offering   = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (requests_q.size() != 0)
                begin
                    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
                        gap_left = $urandom_range(0, 3);
                    else
                    begin
                        in_data <= requests_q.pop_front();
                        next_valid = 1'b1;
                        offering   = 1'b1;
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Long receiver hold-off, counted here and seen by the monitor.
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each accepted result and drives out_stall.
    always @(posedge clk)
    begin
        rop_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                log_mismatch($sformatf("unexpected result pix=%0d cnt=%0d done=%0d",
                    out_data.pixel_value, out_data.edge_count, out_data.batch_done));
            else
            begin
                want = due_results.pop_front();
                if (want.pixel_value !== out_data.pixel_value ||
                    want.edge_count !== out_data.edge_count ||
                    want.batch_done !== out_data.batch_done)
                    log_mismatch($sformatf(
                        "exp pix=%0d cnt=%0d done=%0d, got pix=%0d cnt=%0d done=%0d",
                        want.pixel_value, want.edge_count, want.batch_done,
                        out_data.pixel_value, out_data.edge_count, out_data.batch_done));
            end
        end
        if (hold_left > 0)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct)
        begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_draw(input int x0, input int y0, input int x1, input int y1,
                             input bit finite, input bit last);
        rop_in_t r;
        r = '0;
        r.cmd           = CMD_DRAW;
        r.x_first       = x0[7:0];
        r.y_first       = y0[7:0];
        r.x_second      = x1[7:0];
        r.y_second      = y1[7:0];
        r.coords_finite = finite;
        r.last_box      = last;
        requests_q.push_back(r);
    endtask

    task automatic push_read(input int x, input int y);
        rop_in_t r;
        r = '0;
        r.cmd    = CMD_READ;
        r.read_x = x[5:0];
        r.read_y = y[5:0];
        requests_q.push_back(r);
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > RW - 1) ? RW - 1 : v);
    endfunction

    // In-raster outlines, mostly of modest size, read-backs near the last
    // outline, and the rest fully random fields.
    function automatic rop_in_t random_request();
        rop_in_t     r;
        logic [63:0] bits;
        int          kind;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        bits = {$urandom, $urandom};
        r    = bits[$bits(rop_in_t)-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            x0 = $urandom_range(0, RW - 1);
            y0 = $urandom_range(0, RH - 1);
            if ($urandom_range(0, 9) == 0)
            begin
                x1 = $urandom_range(0, RW - 1);
                y1 = $urandom_range(0, RH - 1);
            end
            else
            begin
                x1 = clamp_coord(x0 + int'($urandom_range(0, 16)) - 8);
                y1 = clamp_coord(y0 + int'($urandom_range(0, 16)) - 8);
            end
            r.cmd           = CMD_DRAW;
            r.x_first       = x0[7:0];
            r.y_first       = y0[7:0];
            r.x_second      = x1[7:0];
            r.y_second      = y1[7:0];
            r.coords_finite = ($urandom_range(0, 19) != 0);
            mark_x = $urandom_range(0, 1) ? x0 : x1;
            mark_y = $urandom_range(0, 1) ? y0 : y1;
        end
        else if (kind < 60)
            r.cmd = CMD_DRAW;
        else if (kind < 80)
        begin
            r.cmd    = CMD_READ;
            r.read_x = mark_x[5:0];
            r.read_y = 6'(clamp_coord(mark_y + int'($urandom_range(0, 2)) - 1));
        end
        else
            r.cmd = CMD_READ;
        return r;
    endfunction

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            requests_q.push_back(random_request());
    endtask

    task automatic wait_drained();
        while (requests_q.size() != 0 || offering || due_results.size() != 0)
            @(posedge clk);
    endtask

    // The block is idle here, so the shadow mode can follow at once.
    task automatic write_mode(input bit mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        acc_mode = mode;
    endtask

    task automatic run_phase(input bit mode, input int n, input int in_pct, input int out_pct);
        write_mode(mode);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        push_random(n);
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < RW * RH; i++)
            shadow_frame[i] = 8'h00;
        edge_total     = '0;
        acc_mode       = 1'b1;
        mismatch_count = 0;
        in_idle_pct    = 20;
        out_idle_pct   = 20;
        mark_x         = 0;
        mark_y         = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests in the reset mode, which accumulates.
        push_read(0, 0);
        push_read(63, 63);
        push_draw(0, 0, 63, 63, 1'b1, 1'b1);
        push_read(0, 0);
        push_read(30, 0);
        push_read(30, 30);
        push_draw(63, 63, 0, 0, 1'b1, 1'b0);
        push_read(0, 63);
        push_draw(0, 0, 63, 63, 1'b1, 1'b0);
        push_read(0, 0);
        push_draw(-128, 127, 127, -128, 1'b0, 1'b1);
        push_draw(-1, 5, 10, 20, 1'b1, 1'b0);
        push_read(10, 12);
        push_draw(-128, -128, 127, 127, 1'b1, 1'b0);
        push_draw(0, 0, 64, 10, 1'b1, 1'b0);
        push_draw(127, 127, 127, 127, 1'b1, 1'b1);
        push_draw(10, 10, 10, 10, 1'b1, 1'b0);
        push_read(10, 10);
        push_draw(5, 5, 5, 40, 1'b1, 1'b0);
        push_read(5, 20);
        push_draw(20, 7, 50, 7, 1'b1, 1'b0);
        push_read(35, 7);
        push_read(0, 5);
        wait_drained();

        run_phase(1'b0, PHASE_ITEMS, 25, 25);

        // Hold the output long enough that the block backs up onto its input.
        write_mode(1'b1);
        in_idle_pct  = 10;
        out_idle_pct = 10;
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 30; i++)
            push_read($urandom_range(0, RW - 1), $urandom_range(0, RH - 1));
        push_random(PHASE_ITEMS - 30);
        wait_drained();

        run_phase(1'b0, PHASE_ITEMS, 40, 5);
        run_phase(1'b1, PHASE_ITEMS, 5, 40);
        run_phase(1'b1, PHASE_ITEMS, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", due_results.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
